// ----- rtl/core/fdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_pkg: finite-difference derivative shared definitions
// Widths, register indexes, scheme codes and the stencil weight table.
// ----------------------------------------------------------------------------
package fdd_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int SCALE_FRAC_BITS = 16;
	localparam int SCALE_BITS      = 32;
	localparam int OUT_BITS        = 40;

	localparam int TAPS         = 9;
	localparam int TAP_IDX_BITS = $clog2(TAPS);
	localparam int WEIGHT_BITS  = 10;
	// largest sum of weight magnitudes is 1088
	localparam int WSUM_BITS    = 11;

	localparam int SUM_BITS   = SAMPLE_BITS + WSUM_BITS;
	localparam int MAG_BITS   = SUM_BITS - 1;
	localparam int HALF_BITS  = (MAG_BITS + 1) / 2;
	localparam int HI_BITS    = MAG_BITS - HALF_BITS;
	localparam int MUL_A_BITS = (SAMPLE_BITS > HALF_BITS + 1) ? SAMPLE_BITS : HALF_BITS + 1;
	localparam int MUL_B_BITS = SCALE_BITS + 1;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int PROD_BITS  = MAG_BITS + SCALE_BITS;

	localparam int SCHEME_BITS = 2;
	localparam int ORDER_BITS  = 3;
	localparam int POINTS_BITS = 3;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = SCALE_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_SCHEME = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORDER  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POINTS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCALE  = 3'd3;

	localparam logic [SCHEME_BITS-1:0] SCHEME_FWD = 2'd0;
	localparam logic [SCHEME_BITS-1:0] SCHEME_CEN = 2'd1;
	localparam logic [SCHEME_BITS-1:0] SCHEME_BWD = 2'd2;

	localparam logic [SCHEME_BITS-1:0] SCHEME_RESET = SCHEME_CEN;
	localparam logic [ORDER_BITS-1:0]  ORDER_RESET  = 3'd1;
	localparam logic [POINTS_BITS-1:0] POINTS_RESET = 3'd3;
	localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = SCALE_BITS'(64'd1 << SCALE_FRAC_BITS);

	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef weight_t [TAPS-1:0] stencil_row_t;

	typedef struct packed {
		logic         valid;
		stencil_row_t w;
	} stencil_t;

	function automatic stencil_row_t mk_row(input int w0, input int w1, input int w2,
			input int w3, input int w4, input int w5, input int w6, input int w7,
			input int w8);
		stencil_row_t r;
		r[0] = weight_t'(w0);
		r[1] = weight_t'(w1);
		r[2] = weight_t'(w2);
		r[3] = weight_t'(w3);
		r[4] = weight_t'(w4);
		r[5] = weight_t'(w5);
		r[6] = weight_t'(w6);
		r[7] = weight_t'(w7);
		r[8] = weight_t'(w8);
		return r;
	endfunction

	// tap 0 oldest, tap 4 centre, tap 8 newest
	function automatic stencil_t stencil_lookup(input logic [SCHEME_BITS-1:0] sch,
			input logic [ORDER_BITS-1:0] ord, input logic [POINTS_BITS-1:0] pts);
		stencil_t st;
		st.valid = 1'b1;
		st.w     = '0;
		unique case ({sch, ord, pts})
			{SCHEME_FWD, 3'd1, 3'd2}: st.w = mk_row(0, 0, 0, 0, -1, 1, 0, 0, 0);
			{SCHEME_FWD, 3'd1, 3'd3}: st.w = mk_row(0, 0, 0, 0, -3, 4, -1, 0, 0);
			{SCHEME_FWD, 3'd1, 3'd4}: st.w = mk_row(0, 0, 0, 0, -11, 18, -9, 2, 0);
			{SCHEME_FWD, 3'd1, 3'd5}: st.w = mk_row(0, 0, 0, 0, -25, 48, -36, 16, -3);
			{SCHEME_FWD, 3'd2, 3'd3}: st.w = mk_row(0, 0, 0, 0, 1, -2, 1, 0, 0);
			{SCHEME_FWD, 3'd2, 3'd4}: st.w = mk_row(0, 0, 0, 0, 2, -5, 4, -1, 0);
			{SCHEME_FWD, 3'd2, 3'd5}: st.w = mk_row(0, 0, 0, 0, 35, -104, 114, -56, 11);
			{SCHEME_FWD, 3'd3, 3'd4}: st.w = mk_row(0, 0, 0, 0, -1, 3, -3, 1, 0);
			{SCHEME_FWD, 3'd3, 3'd5}: st.w = mk_row(0, 0, 0, 0, -5, 18, -24, 14, -3);
			{SCHEME_FWD, 3'd4, 3'd5}: st.w = mk_row(0, 0, 0, 0, 1, -4, 6, -4, 1);
			{SCHEME_CEN, 3'd1, 3'd3}: st.w = mk_row(0, 0, 0, -1, 0, 1, 0, 0, 0);
			{SCHEME_CEN, 3'd1, 3'd5}: st.w = mk_row(0, 0, 1, -8, 0, 8, -1, 0, 0);
			{SCHEME_CEN, 3'd1, 3'd7}: st.w = mk_row(0, -1, 9, -45, 0, 45, -9, 1, 0);
			{SCHEME_CEN, 3'd2, 3'd3}: st.w = mk_row(0, 0, 0, 1, -2, 1, 0, 0, 0);
			{SCHEME_CEN, 3'd2, 3'd5}: st.w = mk_row(0, 0, -1, 16, -30, 16, -1, 0, 0);
			{SCHEME_CEN, 3'd2, 3'd7}: st.w = mk_row(0, 2, -27, 270, -490, 270, -27, 2, 0);
			{SCHEME_CEN, 3'd3, 3'd5}: st.w = mk_row(0, 0, -1, 2, 0, -2, 1, 0, 0);
			{SCHEME_CEN, 3'd3, 3'd7}: st.w = mk_row(0, 1, -8, 13, 0, -13, 8, -1, 0);
			{SCHEME_CEN, 3'd4, 3'd5}: st.w = mk_row(0, 0, 1, -4, 6, -4, 1, 0, 0);
			{SCHEME_CEN, 3'd4, 3'd7}: st.w = mk_row(0, -1, 12, -39, 56, -39, 12, -1, 0);
			{SCHEME_BWD, 3'd1, 3'd2}: st.w = mk_row(0, 0, 0, -1, 1, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd1, 3'd3}: st.w = mk_row(0, 0, 1, -4, 3, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd1, 3'd4}: st.w = mk_row(0, -2, 9, -18, 11, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd1, 3'd5}: st.w = mk_row(3, -16, 36, -48, 25, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd2, 3'd3}: st.w = mk_row(0, 0, 1, -2, 1, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd2, 3'd4}: st.w = mk_row(0, -1, 4, -5, 2, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd2, 3'd5}: st.w = mk_row(11, -56, 114, -104, 35, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd3, 3'd4}: st.w = mk_row(0, -1, 3, -3, 1, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd3, 3'd5}: st.w = mk_row(3, -14, 24, -18, 5, 0, 0, 0, 0);
			{SCHEME_BWD, 3'd4, 3'd5}: st.w = mk_row(1, -4, 6, -4, 1, 0, 0, 0, 0);
			default: st.valid = 1'b0;
		endcase
		return st;
	endfunction

endpackage

// ----- rtl/core/fdd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_if: sample and result channels
// Valid/ready channels carrying one sample beat and one result beat.
// ----------------------------------------------------------------------------
interface fdd_in_if import fdd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface fdd_out_if import fdd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] derivative;
	logic                       stencil_invalid;
	logic                       saturated;

	modport source (output valid, output derivative, output stencil_invalid,
		output saturated, input ready);
	modport sink   (input valid, input derivative, input stencil_invalid,
		input saturated, output ready);
endinterface

// ----- rtl/core/fdd_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_mul: shared signed multiplier
// One registered signed multiply, reused for the taps and for the scaling.
// ----------------------------------------------------------------------------
module fdd_mul import fdd_pkg::*; (
	input  logic                         clk,
	input  logic signed [MUL_A_BITS-1:0] a,
	input  logic signed [MUL_B_BITS-1:0] b,
	output logic signed [MUL_P_BITS-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- rtl/core/finite_difference_derivative_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finite_difference_derivative_unit: streaming stencil derivative
// Nine-sample window, table stencils, Q16.16 scaling, 40-bit saturation.
// ----------------------------------------------------------------------------
// Each accepted sample shifts into a nine-sample window and produces one
// result: the stencil-weighted sum of the window, for the centre sample four
// beats back, times the unsigned scale register, clipped to 40 bits. One
// multiplier does all the work under a small sequencer: nine tap products,
// then the magnitude times scale in two halves, so a new sample is taken
// only once the previous one has passed through all of these steps.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and only the final step waits for the result to drain. An
// unsupported scheme/order/point count gives zero and stencil_invalid.
// Registers: 0 scheme, 1 deriv_order, 2 point_count, 3 scale; write only
// while the block is idle.
// ----------------------------------------------------------------------------
module finite_difference_derivative_unit import fdd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	fdd_in_if.sink                   samples,
	fdd_out_if.source                results
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAP,
		S_TAP_LAST,
		S_ABS,
		S_SCL_LO,
		S_SCL_HI,
		S_SCL_ADD,
		S_OUT
	} state_t;

	state_t                        state_q;
	logic [TAP_IDX_BITS-1:0]       cnt_q;
	logic                          out_valid_q;

	logic [SCHEME_BITS-1:0]        scheme_q;
	logic [ORDER_BITS-1:0]         order_q;
	logic [POINTS_BITS-1:0]        points_q;
	logic [SCALE_BITS-1:0]         scale_q;
	logic signed [SAMPLE_BITS-1:0] window_q [TAPS];

	logic signed [SUM_BITS-1:0]    acc_q;
	logic                          neg_q;
	logic [MAG_BITS-1:0]           mag_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic signed [OUT_BITS-1:0]    derivative_q;
	logic                          invalid_q;
	logic                          sat_q;

	logic signed [MUL_A_BITS-1:0]  mul_a;
	logic signed [MUL_B_BITS-1:0]  mul_b;
	logic signed [MUL_P_BITS-1:0]  mul_p;

	stencil_t                      stencil;
	logic                          in_accept;
	logic                          out_load;
	logic [PROD_BITS-1:0]          lim;
	logic [PROD_BITS-1:0]          prod_neg;
	logic                          sat;
	logic signed [OUT_BITS-1:0]    res;

	assign stencil   = stencil_lookup(scheme_q, order_q, points_q);
	assign in_accept = samples.valid && samples.ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || results.ready);

	assign samples.ready           = (state_q == S_IDLE);
	assign results.valid           = out_valid_q;
	assign results.derivative      = derivative_q;
	assign results.stencil_invalid = invalid_q;
	assign results.saturated       = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= SCHEME_RESET;
			order_q  <= ORDER_RESET;
			points_q <= POINTS_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCHEME: scheme_q <= cfg_data[SCHEME_BITS-1:0];
				REG_ORDER:  order_q  <= cfg_data[ORDER_BITS-1:0];
				REG_POINTS: points_q <= cfg_data[POINTS_BITS-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				window_q[i] <= '0;
			end
		end else if (in_accept) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				window_q[i] <= window_q[i + 1];
			end
			window_q[TAPS - 1] <= samples.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						cnt_q   <= '0;
						state_q <= S_TAP;
					end
				end
				S_TAP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == TAP_IDX_BITS'(TAPS - 1)) begin
						state_q <= S_TAP_LAST;
					end
				end
				S_TAP_LAST: state_q <= S_ABS;
				S_ABS:      state_q <= S_SCL_LO;
				S_SCL_LO:   state_q <= S_SCL_HI;
				S_SCL_HI:   state_q <= S_SCL_ADD;
				S_SCL_ADD:  state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TAP: begin
				mul_a = MUL_A_BITS'(window_q[cnt_q]);
				mul_b = MUL_B_BITS'($signed(stencil.w[cnt_q]));
			end
			S_SCL_LO: begin
				mul_a = MUL_A_BITS'($signed({1'b0, mag_q[HALF_BITS-1:0]}));
				mul_b = MUL_B_BITS'($signed({1'b0, scale_q}));
			end
			S_SCL_HI: begin
				mul_a = MUL_A_BITS'($signed({1'b0, mag_q[MAG_BITS-1:HALF_BITS]}));
				mul_b = MUL_B_BITS'($signed({1'b0, scale_q}));
			end
			default: ;
		endcase
	end

	fdd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// magnitude limit depends on the sign of the sum
	always_comb begin
		lim      = neg_q ? PROD_BITS'({1'b1, {(OUT_BITS - 1){1'b0}}})
			: PROD_BITS'({1'b0, {(OUT_BITS - 1){1'b1}}});
		sat      = prod_q > lim;
		prod_neg = '0 - prod_q;
		if (sat) begin
			res = neg_q ? {1'b1, {(OUT_BITS - 1){1'b0}}} : {1'b0, {(OUT_BITS - 1){1'b1}}};
		end else if (neg_q) begin
			res = prod_neg[OUT_BITS-1:0];
		end else begin
			res = prod_q[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			acc_q <= '0;
		end
		case (state_q)
			S_TAP: begin
				if (cnt_q != '0) begin
					acc_q <= acc_q + $signed(mul_p[SUM_BITS-1:0]);
				end
			end
			S_TAP_LAST: acc_q <= acc_q + $signed(mul_p[SUM_BITS-1:0]);
			S_ABS: begin
				neg_q <= acc_q[SUM_BITS-1];
				mag_q <= acc_q[SUM_BITS-1] ? MAG_BITS'(-acc_q) : MAG_BITS'(acc_q);
			end
			S_SCL_HI:  prod_q <= PROD_BITS'(mul_p[HALF_BITS+SCALE_BITS-1:0]);
			S_SCL_ADD: prod_q <= prod_q
				+ (PROD_BITS'(mul_p[HI_BITS+SCALE_BITS-1:0]) << HALF_BITS);
			default: ;
		endcase
		if (out_load) begin
			derivative_q <= res;
			sat_q        <= sat;
			invalid_q    <= !stencil.valid;
		end
	end

endmodule

// ----- rtl/core/fdd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_checker: port-level checks for the derivative unit
// Watches the sample and result channels and the result flags.
// ----------------------------------------------------------------------------
module fdd_checker import fdd_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [OUT_BITS-1:0] derivative,
	input logic                       stencil_invalid,
	input logic                       saturated
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(derivative)
			&& $stable(saturated) && $stable(stencil_invalid))
	else $error("result beat changed while stalled");

	// one sample at a time: busy right after a beat is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("sample taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stencil_invalid |-> derivative == '0 && !saturated)
	else $error("invalid stencil gave a nonzero result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			derivative == {1'b0, {(OUT_BITS - 1){1'b1}}}
			|| derivative == {1'b1, {(OUT_BITS - 1){1'b0}}})
	else $error("saturated result not at a bound");

endmodule

bind finite_difference_derivative_unit fdd_checker u_fdd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (samples.valid),
	.in_ready        (samples.ready),
	.out_valid       (results.valid),
	.out_ready       (results.ready),
	.derivative      (results.derivative),
	.stencil_invalid (results.stencil_invalid),
	.saturated       (results.saturated)
);

// ----- bench/finite_difference_derivative_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finite_difference_derivative_unit_test: stencil derivative bench
// Streams samples through the unit under many scheme/order/point-count and
// scale settings. A scoreboard keeps its own window and stencil table,
// predicts every result beat and compares it in order, field by field.
// ----------------------------------------------------------------------------
module finite_difference_derivative_unit_test import fdd_pkg::*; ();

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 10;
	localparam int ITEMS_TOTAL  = 950;
	localparam int BLOCK_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [SCHEME_BITS-1:0] SCHEME_SPARE = 2'd3;
	localparam longint DERIV_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
	localparam longint DERIV_MIN = -(longint'(1) <<< (OUT_BITS - 1));

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [SCHEME_BITS-1:0] scheme;
		logic [ORDER_BITS-1:0]  order;
		logic [POINTS_BITS-1:0] points;
	} stencil_sel_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] derivative;
		logic                       stencil_invalid;
		logic                       saturated;
	} deriv_beat_t;

	class derivative_scoreboard;
		logic [SCHEME_BITS-1:0] scheme;
		logic [ORDER_BITS-1:0]  order;
		logic [POINTS_BITS-1:0] points;
		logic [SCALE_BITS-1:0]  scale;
		sample_t                window [TAPS];
		deriv_beat_t            expected_q [$];
		int                     mismatches;
		int                     beats_checked;
		int                     saturated_seen;
		int                     invalid_seen;

		function new();
			scheme = SCHEME_RESET;
			order  = ORDER_RESET;
			points = POINTS_RESET;
			scale  = SCALE_RESET;
			foreach (window[i]) window[i] = '0;
			mismatches     = 0;
			beats_checked  = 0;
			saturated_seen = 0;
			invalid_seen   = 0;
		endfunction

		// tap 0 oldest, tap 4 centre, tap 8 newest
		static function bit stencil_weights(input logic [SCHEME_BITS-1:0] sch,
				input logic [ORDER_BITS-1:0] ord, input logic [POINTS_BITS-1:0] pts,
				output int w [TAPS]);
			stencil_weights = 1'b1;
			w = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
			case ({sch, ord, pts})
				{SCHEME_FWD, 3'd1, 3'd2}: w = '{0, 0, 0, 0, -1, 1, 0, 0, 0};
				{SCHEME_FWD, 3'd1, 3'd3}: w = '{0, 0, 0, 0, -3, 4, -1, 0, 0};
				{SCHEME_FWD, 3'd1, 3'd4}: w = '{0, 0, 0, 0, -11, 18, -9, 2, 0};
				{SCHEME_FWD, 3'd1, 3'd5}: w = '{0, 0, 0, 0, -25, 48, -36, 16, -3};
				{SCHEME_FWD, 3'd2, 3'd3}: w = '{0, 0, 0, 0, 1, -2, 1, 0, 0};
				{SCHEME_FWD, 3'd2, 3'd4}: w = '{0, 0, 0, 0, 2, -5, 4, -1, 0};
				{SCHEME_FWD, 3'd2, 3'd5}: w = '{0, 0, 0, 0, 35, -104, 114, -56, 11};
				{SCHEME_FWD, 3'd3, 3'd4}: w = '{0, 0, 0, 0, -1, 3, -3, 1, 0};
				{SCHEME_FWD, 3'd3, 3'd5}: w = '{0, 0, 0, 0, -5, 18, -24, 14, -3};
				{SCHEME_FWD, 3'd4, 3'd5}: w = '{0, 0, 0, 0, 1, -4, 6, -4, 1};
				{SCHEME_CEN, 3'd1, 3'd3}: w = '{0, 0, 0, -1, 0, 1, 0, 0, 0};
				{SCHEME_CEN, 3'd1, 3'd5}: w = '{0, 0, 1, -8, 0, 8, -1, 0, 0};
				{SCHEME_CEN, 3'd1, 3'd7}: w = '{0, -1, 9, -45, 0, 45, -9, 1, 0};
				{SCHEME_CEN, 3'd2, 3'd3}: w = '{0, 0, 0, 1, -2, 1, 0, 0, 0};
				{SCHEME_CEN, 3'd2, 3'd5}: w = '{0, 0, -1, 16, -30, 16, -1, 0, 0};
				{SCHEME_CEN, 3'd2, 3'd7}: w = '{0, 2, -27, 270, -490, 270, -27, 2, 0};
				{SCHEME_CEN, 3'd3, 3'd5}: w = '{0, 0, -1, 2, 0, -2, 1, 0, 0};
				{SCHEME_CEN, 3'd3, 3'd7}: w = '{0, 1, -8, 13, 0, -13, 8, -1, 0};
				{SCHEME_CEN, 3'd4, 3'd5}: w = '{0, 0, 1, -4, 6, -4, 1, 0, 0};
				{SCHEME_CEN, 3'd4, 3'd7}: w = '{0, -1, 12, -39, 56, -39, 12, -1, 0};
				{SCHEME_BWD, 3'd1, 3'd2}: w = '{0, 0, 0, -1, 1, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd1, 3'd3}: w = '{0, 0, 1, -4, 3, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd1, 3'd4}: w = '{0, -2, 9, -18, 11, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd1, 3'd5}: w = '{3, -16, 36, -48, 25, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd2, 3'd3}: w = '{0, 0, 1, -2, 1, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd2, 3'd4}: w = '{0, -1, 4, -5, 2, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd2, 3'd5}: w = '{11, -56, 114, -104, 35, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd3, 3'd4}: w = '{0, -1, 3, -3, 1, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd3, 3'd5}: w = '{3, -14, 24, -18, 5, 0, 0, 0, 0};
				{SCHEME_BWD, 3'd4, 3'd5}: w = '{1, -4, 6, -4, 1, 0, 0, 0, 0};
				default: stencil_weights = 1'b0;
			endcase
		endfunction

		function void write_reg(input logic [CFG_IDX_BITS-1:0] idx,
				input logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_SCHEME: scheme = data[SCHEME_BITS-1:0];
				REG_ORDER:  order  = data[ORDER_BITS-1:0];
				REG_POINTS: points = data[POINTS_BITS-1:0];
				REG_SCALE:  scale  = data[SCALE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(input sample_t s);
			int          w [TAPS];
			bit          found;
			longint      acc;
			longint      prod;
			deriv_beat_t exp_beat;
			for (int i = 0; i < TAPS - 1; i++)
				window[i] = window[i + 1];
			window[TAPS-1] = s;
			found = stencil_weights(scheme, order, points, w);
			acc = 0;
			for (int i = 0; i < TAPS; i++)
				acc += longint'(w[i]) * longint'(window[i]);
			prod = acc * longint'(scale);
			exp_beat.stencil_invalid = !found;
			exp_beat.saturated       = (prod > DERIV_MAX) || (prod < DERIV_MIN);
			if (prod > DERIV_MAX)
				exp_beat.derivative = DERIV_MAX[OUT_BITS-1:0];
			else if (prod < DERIV_MIN)
				exp_beat.derivative = DERIV_MIN[OUT_BITS-1:0];
			else
				exp_beat.derivative = prod[OUT_BITS-1:0];
			expected_q.push_back(exp_beat);
		endfunction

		function void check_result(input logic signed [OUT_BITS-1:0] derivative,
				input logic stencil_invalid, input logic saturated);
			deriv_beat_t exp_beat;
			beats_checked++;
			if (saturated === 1'b1)
				saturated_seen++;
			if (stencil_invalid === 1'b1)
				invalid_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result beat d=%0d inv=%b sat=%b", $realtime,
						derivative, stencil_invalid, saturated);
				return;
			end
			exp_beat = expected_q.pop_front();
			if (derivative !== exp_beat.derivative
					|| stencil_invalid !== exp_beat.stencil_invalid
					|| saturated !== exp_beat.saturated) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: mismatch exp d=%0d inv=%b sat=%b got d=%0d inv=%b sat=%b",
						$realtime, exp_beat.derivative, exp_beat.stencil_invalid,
						exp_beat.saturated, derivative, stencil_invalid, saturated);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	fdd_in_if  sample_ch ();
	fdd_out_if result_ch ();

	derivative_scoreboard sb = new();

	int  cycle_count = 0;
	int  samples_sent = 0;
	int  settings_used = 0;
	bit  send_gaps = 1'b1;
	bit  recv_stalls = 1'b1;

	stencil_sel_t valid_sels [$];

	finite_difference_derivative_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (sample_ch),
		.results   (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.derivative, result_ch.stencil_invalid,
				result_ch.saturated);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("status: fail");
		$finish;
	end

	// result side back-pressure
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = recv_stalls ? $urandom_range(0, 4) : 0;
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	task automatic push_sample(input sample_t s);
		int gap;
		gap = send_gaps ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(s);
		samples_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
	endtask

	// upper data bits carry junk half the time; the register must mask them
	task automatic set_config(input stencil_sel_t sel, input logic [SCALE_BITS-1:0] scl);
		logic [CFG_DATA_BITS-1:0] junk;
		junk = $urandom_range(0, 1) ? CFG_DATA_BITS'($urandom) : '0;
		write_reg(REG_SCHEME, {junk[CFG_DATA_BITS-1:SCHEME_BITS], sel.scheme});
		write_reg(REG_ORDER, {junk[CFG_DATA_BITS-1:ORDER_BITS], sel.order});
		write_reg(REG_POINTS, {junk[CFG_DATA_BITS-1:POINTS_BITS], sel.points});
		write_reg(REG_SCALE, scl);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SCALE + CFG_IDX_BITS'($urandom_range(1, 4)), CFG_DATA_BITS'($urandom));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int                    w [TAPS];
		int                    n;
		int                    mode;
		int                    phase;
		int                    v;
		int                    c0, c1, c2, c3;
		stencil_sel_t          sel;
		logic [SCALE_BITS-1:0] scl;

		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready  = 1'b0;

		for (int sc = 0; sc < 4; sc++)
			for (int od = 0; od < 8; od++)
				for (int pt = 0; pt < 8; pt++)
					if (derivative_scoreboard::stencil_weights(SCHEME_BITS'(sc), ORDER_BITS'(od),
							POINTS_BITS'(pt), w))
						valid_sels.push_back({SCHEME_BITS'(sc), ORDER_BITS'(od),
							POINTS_BITS'(pt)});

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, field extremes and bit patterns
		push_sample(16'sh7fff);
		push_sample(-16'sh8000);
		push_sample(16'sh0000);
		push_sample(-16'sh0001);
		push_sample(16'sh0001);
		push_sample(16'sh5555);
		push_sample(sample_t'(16'haaaa));
		push_sample(16'sh7fff);
		push_sample(16'sh7fff);
		push_sample(-16'sh8000);
		drain_results();

		// widest stencil at full scale: clips both ways
		set_config('{SCHEME_CEN, 3'd2, 3'd7}, '1);
		for (int i = 0; i < 6; i++)
			push_sample(i[0] ? -16'sh8000 : 16'sh7fff);
		drain_results();

		// no stencil for the spare scheme code
		set_config('{SCHEME_SPARE, 3'd1, 3'd3}, SCALE_RESET);
		push_sample(16'sh7fff);
		push_sample(-16'sh8000);
		push_sample(16'sh1234);
		drain_results();

		// zero scale kills any sum
		set_config('{SCHEME_FWD, 3'd1, 3'd2}, '0);
		push_sample(-16'sh8000);
		push_sample(16'sh7fff);
		push_sample(16'sh7fff);
		drain_results();

		phase = 0;
		while (samples_sent < ITEMS_TOTAL) begin
			if (phase < valid_sels.size())
				sel = valid_sels[phase];
			else if ($urandom_range(0, 4) == 0)
				sel = stencil_sel_t'($urandom_range(0, 255));
			else
				sel = valid_sels[$urandom_range(0, valid_sels.size() - 1)];
			case ($urandom_range(0, 6))
				0: scl = '0;
				1: scl = '1;
				2: scl = SCALE_RESET;
				3: scl = SCALE_BITS'(1);
				4: scl = SCALE_BITS'($urandom_range(1, 1 << 20));
				default: scl = SCALE_BITS'($urandom);
			endcase
			set_config(sel, scl);
			send_gaps   = $urandom_range(0, 3) != 0;
			recv_stalls = $urandom_range(0, 3) != 0;
			n    = $urandom_range(12, 36);
			mode = $urandom_range(0, 2);
			c0 = int'($urandom_range(0, 40000)) - 20000;
			c1 = int'($urandom_range(0, 1000)) - 500;
			c2 = int'($urandom_range(0, 80)) - 40;
			c3 = int'($urandom_range(0, 4)) - 2;
			for (int k = 0; k < n; k++) begin
				case (mode)
					0: v = c0 + c1 * k + c2 * k * k + c3 * k * k * k
						+ int'($urandom_range(0, 6)) - 3;
					1: v = int'($urandom_range(0, 65535)) - 32768;
					default: begin
						if ($urandom_range(0, 1))
							v = $urandom_range(0, 1) ? 32767 : -32768;
						else
							v = int'($urandom_range(0, 65535)) - 32768;
					end
				endcase
				if (v > 32767)
					v = 32767;
				else if (v < -32768)
					v = -32768;
				push_sample(sample_t'(v));
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
			drain_results();
			phase++;
		end

		repeat (2 * BLOCK_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			sb.mismatches++;
			$display("%0d expected result beats never arrived", sb.pending());
		end
		$display("%0d samples over %0d register settings, %0d distinct stencils",
			samples_sent, settings_used, valid_sels.size());
		$display("%0d result beats: %0d saturated, %0d without a stencil, %0d mismatches",
			sb.beats_checked, sb.saturated_seen, sb.invalid_seen, sb.mismatches);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/fdd_pkg.sv
rtl/core/fdd_if.sv
rtl/core/fdd_mul.sv
rtl/core/finite_difference_derivative_unit.sv
rtl/core/fdd_checker.sv
bench/finite_difference_derivative_unit_test.sv
